>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL; they expand to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, ante, cons)
`define ASSERT_ALWAYS(label, expr)
`endif

`endif

>>> rtl/core/s8fr_pkg.sv
// Package: constants, codes and types of the frame receiver.
`timescale 1ns / 1ps
package s8fr_pkg;

  localparam int unsigned MaxFrameLengthDefault = 255;
  localparam logic [7:0]  FrameLengthReset      = 8'd16;

  localparam logic [7:0] HeaderByte  = 8'h5a;
  localparam logic [7:0] TailByte    = 8'ha5;
  localparam logic [7:0] ModeData    = 8'h00;
  localparam logic [7:0] ModeCommand = 8'h01;

  // Reported frame status
  typedef enum logic [1:0] {
    FS_PROGRESS = 2'd0,
    FS_REJECT   = 2'd1,
    FS_DATA     = 2'd2,
    FS_CMD      = 2'd3
  } frame_status_e;

  // Outcome of the per-byte checks
  typedef enum logic [1:0] {
    CK_BUSY,
    CK_REJECT,
    CK_DONE
  } check_e;

  // Registered input item handed to the frame logic
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } item_t;

endpackage

>>> rtl/core/sum8_frame_receiver.sv
// Top level: framed byte receiver with header, mode, checksum and tail checks.
// A byte accepted on the slave side passes the input register, then the result register that drives the master side.
// Throughput: one byte per cycle while the master side accepts; the frame state updates with each byte taken.
// Under backpressure the input register holds one byte; s_axis_tready is high while it is empty or being taken.
// Reset: asynchronous, active low; waits for a header, data mode, length 16.
`timescale 1ns / 1ps
module sum8_frame_receiver #(
  parameter int unsigned MAX_FRAME_LENGTH = s8fr_pkg::MaxFrameLengthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] byte_out, [15:8] byte_position,
                                      // [17:16] frame_status, [23:18] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i      // [7:0] frame_length
);
  import s8fr_pkg::*;

  localparam logic [7:0] MaxLen = 8'(MAX_FRAME_LENGTH);

  logic [7:0] frame_length_q, frame_length_d;
  item_t      item;
  logic       take;

  assign cfg_ready_o    = 1'b1;
  assign frame_length_d = (cfg_data_i > MaxLen) ? MaxLen : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_length_q <= FrameLengthReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      frame_length_q <= frame_length_d;
    end
  end

  s8fr_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .take_i        (take),
    .item_o        (item)
  );

  s8fr_frame_core u_frame_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item),
    .take_o         (take),
    .frame_length_i (frame_length_q),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata)
  );

endmodule

>>> rtl/core/s8fr_in_stage.sv
// Input register stage with stream handshake.
`timescale 1ns / 1ps
module s8fr_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] byte_in
  input  logic          take_i,
  output s8fr_pkg::item_t item_o
);
  import s8fr_pkg::*;

  logic       valid_q;
  logic [7:0] data_q;

  assign s_axis_tready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      data_q <= s_axis_tdata;
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.data  = data_q;

endmodule

>>> rtl/core/s8fr_frame_core.sv
// Frame state, per-byte checks and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module s8fr_frame_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  s8fr_pkg::item_t item_i,
  output logic            take_o,
  input  logic [7:0]      frame_length_i,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [23:0]     m_axis_tdata   // [7:0] byte_out, [15:8] byte_position,
                                         // [17:16] frame_status, [23:18] zero
);
  import s8fr_pkg::*;

  logic          resync_q, resync_d;
  logic [7:0]    pos_q, pos_d;
  logic          cmd_q, cmd_d;
  logic [7:0]    sum_q, sum_d;
  logic          out_valid_q;
  logic [7:0]    out_byte_q;
  logic [7:0]    out_pos_q;
  frame_status_e out_status_q, status_d;

  logic [7:0] b;
  logic [7:0] pos;
  logic [7:0] sum;
  logic [7:0] sum_at;
  logic [7:0] tail_at;
  logic       cmd_mode;
  check_e     chk;

  assign take_o = item_i.valid && (!out_valid_q || m_axis_tready);

  always_comb begin
    b        = item_i.data;
    pos      = resync_q ? 8'd0 : pos_q;
    sum      = resync_q ? 8'd0 : sum_q;
    sum_at   = frame_length_i - 8'd2;
    tail_at  = frame_length_i - 8'd1;
    cmd_mode = cmd_q;
    chk      = CK_BUSY;

    if (pos == 8'd0) begin
      chk = (b == HeaderByte) ? CK_BUSY : CK_REJECT;
    end else if (pos == 8'd1) begin
      if (b == ModeData) begin
        cmd_mode = 1'b0;
      end else if (b == ModeCommand) begin
        cmd_mode = 1'b1;
      end
    end

    // later checks override earlier ones
    if (!cmd_mode) begin
      if (pos == sum_at) begin
        chk = (b == sum) ? CK_BUSY : CK_REJECT;
      end else if (pos == tail_at) begin
        chk = (b == TailByte) ? CK_DONE : CK_REJECT;
      end
    end else if (pos == 8'd3) begin
      chk = (b == TailByte) ? CK_DONE : CK_REJECT;
    end

    sum_d    = sum + b;
    pos_d    = pos + 8'd1;
    cmd_d    = cmd_mode;
    resync_d = 1'b1;
    status_d = FS_PROGRESS;
    case (chk)
      CK_DONE: begin
        status_d = cmd_mode ? FS_CMD : FS_DATA;
        cmd_d    = 1'b0;
      end
      CK_REJECT: begin
        status_d = FS_REJECT;
      end
      default: begin
        resync_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resync_q    <= 1'b1;
      pos_q       <= 8'd0;
      cmd_q       <= 1'b0;
      sum_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        resync_q <= resync_d;
        pos_q    <= pos_d;
        cmd_q    <= cmd_d;
        sum_q    <= sum_d;
      end
      if (take_o) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_byte_q   <= b;
      out_pos_q    <= pos;
      out_status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_status_q, out_pos_q, out_byte_q};

  // shown result always matches the state it left behind
  `ASSERT_IMPLY(a_end_resyncs, out_valid_q && out_status_q != FS_PROGRESS, resync_q)
  `ASSERT_IMPLY(a_busy_continues, out_valid_q && out_status_q == FS_PROGRESS, !resync_q)
  `ASSERT_IMPLY(a_done_clears_mode,
                out_valid_q && (out_status_q == FS_DATA || out_status_q == FS_CMD), !cmd_q)
  `ASSERT_IMPLY(a_pos_follows, out_valid_q && !resync_q, pos_q == out_pos_q + 8'd1)

endmodule

>>> tb/sv/sum8_frame_receiver_tb.sv
// Self-checking testbench for the framed byte receiver.
`timescale 1ns / 1ps
module sum8_frame_receiver_tb;
  import s8fr_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned TargetBytes = 1700;
  localparam int unsigned DrainCycles = 8;

  // Echo as packed on the master side, lowest field in the lowest bits
  typedef struct packed {
    logic [5:0]    pad;
    frame_status_e status;
    logic [7:0]    pos;
    logic [7:0]    data;
  } echo_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] byte_in
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;            // [7:0] byte_out, [15:8] byte_position,
                                        // [17:16] frame_status, [23:18] zero
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i    = 8'h00;   // [7:0] frame_length

  sum8_frame_receiver DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Receiver-side mirror of the frame state
  logic [7:0] frame_len     = FrameLengthReset;
  logic       need_header   = 1'b1;
  logic [7:0] pos_count     = 8'd0;
  logic       in_cmd_mode   = 1'b0;
  logic [7:0] byte_sum      = 8'd0;

  echo_t      pending_echoes[$];
  logic [7:0] frame_buf[$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  int unsigned cycle_count    = 0;
  logic        steady_tx      = 1'b0;

  function automatic echo_t predict_echo(logic [7:0] b);
    echo_t      e;
    logic [7:0] p;
    logic [7:0] sum_at;
    logic [7:0] tail_at;
    check_e     ck;
    if (need_header) begin
      pos_count = 8'd0;
      byte_sum  = 8'd0;
    end
    p       = pos_count;
    sum_at  = frame_len + 8'd254;
    tail_at = frame_len + 8'd255;
    ck      = CK_BUSY;
    if (p == 8'd0) begin
      ck = (b == HeaderByte) ? CK_BUSY : CK_REJECT;
    end else if (p == 8'd1) begin
      if (b == ModeData) in_cmd_mode = 1'b0;
      else if (b == ModeCommand) in_cmd_mode = 1'b1;
    end
    // later checks override the header verdict
    if (!in_cmd_mode) begin
      if (p == sum_at) ck = (b == byte_sum) ? CK_BUSY : CK_REJECT;
      else if (p == tail_at) ck = (b == TailByte) ? CK_DONE : CK_REJECT;
    end else if (p == 8'd3) begin
      ck = (b == TailByte) ? CK_DONE : CK_REJECT;
    end
    byte_sum  = byte_sum + b;
    pos_count = p + 8'd1;
    e.pad  = '0;
    e.pos  = p;
    e.data = b;
    case (ck)
      CK_DONE: begin
        e.status    = in_cmd_mode ? FS_CMD : FS_DATA;
        in_cmd_mode = 1'b0;
        need_header = 1'b1;
      end
      CK_REJECT: begin
        e.status    = FS_REJECT;
        need_header = 1'b1;
      end
      default: begin
        e.status    = FS_PROGRESS;
        need_header = 1'b0;
      end
    endcase
    return e;
  endfunction

  function automatic int unsigned tx_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_tx || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Called at a rising edge; returns at the edge that accepts the byte.
  task automatic push_rx_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_echoes.insert(pending_echoes.size(), predict_echo(b));
    bytes_sent++;
  endtask

  task automatic send_frame_buf();
    foreach (frame_buf[i]) push_rx_byte(frame_buf[i]);
    frame_buf.delete();
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_echoes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_frame_length(input logic [7:0] len);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    frame_len = (len > MaxFrameLengthDefault) ? MaxFrameLengthDefault[7:0] : len;
  endtask

  // Data frame for the current length, one bit flipped if corrupt is set; the whole 256 positions for length 0
  task automatic build_data_frame(input bit corrupt);
    int unsigned n;
    logic [7:0]  sum;
    logic [7:0]  b;
    int unsigned hit;
    n   = (frame_len == 8'd0) ? 256 : 32'(frame_len);
    sum = 8'd0;
    hit = $urandom_range(0, n - 1);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n - 1) b = TailByte;
      else if (i == n - 2) b = sum;
      else if (i == 0) b = HeaderByte;
      else if (i == 1) b = ModeData;
      else b = 8'($urandom_range(0, 255));
      if (corrupt && i == hit) b = b ^ (8'd1 << $urandom_range(0, 7));
      frame_buf.insert(frame_buf.size(), b);
      sum = sum + b;
    end
  endtask

  task automatic build_command_frame();
    int unsigned r;
    r = $urandom_range(0, 99);
    frame_buf.insert(frame_buf.size(), HeaderByte);
    frame_buf.insert(frame_buf.size(),
                     (r < 15) ? 8'($urandom_range(2, 255)) : ModeCommand);
    frame_buf.insert(frame_buf.size(), 8'($urandom_range(0, 255)));
    frame_buf.insert(frame_buf.size(),
                     (r >= 80) ? 8'($urandom_range(0, 255)) : TailByte);
  endtask

  task automatic build_noise();
    int unsigned n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) frame_buf.insert(frame_buf.size(), HeaderByte);
      else frame_buf.insert(frame_buf.size(), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_reset_length();
    build_data_frame(1'b0);
    send_frame_buf();
  endtask

  task automatic test_directed_cases();
    write_frame_length(8'd4);
    frame_buf = '{
      8'h5a, 8'h00, 8'h5a, 8'ha5,   // good data frame
      8'h00, 8'hff,                 // bad headers
      8'h5a, 8'h01, 8'h33, 8'ha5,   // good command frame
      8'h5a, 8'h01, 8'h00, 8'h00,   // command tail wrong, mode stays command
      8'h5a, 8'h7f, 8'hff, 8'ha5,   // unknown mode byte keeps command mode
      8'h5a, 8'h00, 8'h00,          // bad checksum
      8'h5a, 8'h00, 8'h5a, 8'hff    // bad tail
    };
    send_frame_buf();
  endtask

  task automatic test_length_extremes();
    logic [7:0] lens[5];
    lens = '{8'd255, 8'd0, 8'd1, 8'd2, 8'd3};
    foreach (lens[i]) begin
      write_frame_length(lens[i]);
      build_data_frame(1'b0);
      build_command_frame();
      build_noise();
      build_data_frame(1'b1);
      send_frame_buf();
    end
  endtask

  // Tops the total up to the target byte count
  task automatic test_random_traffic();
    int unsigned r;
    int unsigned frames;
    logic [7:0]  len;
    while (bytes_sent < TargetBytes) begin
      r = $urandom_range(0, 99);
      if (r < 80) len = 8'($urandom_range(4, 24));
      else if (r < 90) len = 8'($urandom_range(25, 60));
      else if (r < 95) len = 8'($urandom_range(0, 3));
      else len = 8'($urandom_range(61, 255));
      write_frame_length(len);
      steady_tx = ($urandom_range(0, 3) == 0);
      frames = (len == 8'd0 || len > 8'd60) ? 1 : $urandom_range(3, 10);
      repeat (frames) begin
        r = $urandom_range(0, 99);
        if (r < 70) build_data_frame($urandom_range(0, 9) == 0);
        else if (r < 85) build_command_frame();
        else build_noise();
        send_frame_buf();
      end
    end
    steady_tx = 1'b0;
  endtask

  // Downstream stalls: short and long ones, with stall-free stretches
  int unsigned stall_left = 0;
  int unsigned calm_left  = 0;
  always @(posedge clk_i) begin
    int unsigned r;
    r = $urandom_range(0, 99);
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (calm_left != 0) calm_left--;
      else if (r < 4) calm_left = $urandom_range(50, 300);
      else if (r < 20) stall_left = $urandom_range(1, 3);
      else if (r < 23) stall_left = $urandom_range(8, 30);
    end
  end

  always @(posedge clk_i) begin
    echo_t got;
    echo_t want;
    got = echo_t'(m_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_echoes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: byte %02h pos %0d status %0d",
                   got.data, got.pos, got.status);
      end else begin
        want = pending_echoes.pop_front();
        if (got.data !== want.data || got.pos !== want.pos || got.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: expected byte %02h pos %0d status %0d, ",
                      "got byte %02h pos %0d status %0d"},
                     want.data, want.pos, want.status, got.data, got.pos, got.status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_length();
    test_directed_cases();
    test_length_extremes();
    test_random_traffic();
    wait_idle();
    if (pending_echoes.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/s8fr_pkg.sv
rtl/core/s8fr_in_stage.sv
rtl/core/s8fr_frame_core.sv
rtl/core/sum8_frame_receiver.sv
tb/sv/sum8_frame_receiver_tb.sv
